[sv/kcd_pkg.sv]
`default_nettype none

package kcd_pkg;

   localparam int unsigned DATA_W = 8;
   localparam int unsigned PADDR_W = 4;
   localparam int unsigned PDATA_W = 32;

   localparam logic [DATA_W-1:0] CLICK_MIN_RESET = 8'd8;
   localparam logic [DATA_W-1:0] CLICK_MAX_RESET = 8'd120;
   localparam logic [DATA_W-1:0] LONG_PRESS_RESET = 8'd254;
   localparam logic [DATA_W-1:0] CLICK_HOLD_RESET = 8'hff;
   localparam logic [DATA_W-1:0] PRESS_SATURATE = 8'd255;

   typedef enum logic [1:0] {
      REG_CLICK_MIN  = 2'd0,
      REG_CLICK_MAX  = 2'd1,
      REG_LONG_PRESS = 2'd2,
      REG_CLICK_HOLD = 2'd3
   } cfg_reg_type;

   typedef enum logic {
      KIND_TICK    = 1'b0,
      KIND_CONSUME = 1'b1
   } kind_type;

   typedef struct packed {
      logic [DATA_W-1:0] click_min_time;
      logic [DATA_W-1:0] click_max_time;
      logic [DATA_W-1:0] long_press_time;
      logic [DATA_W-1:0] click_hold_ticks;
   } cfg_type;

   typedef struct packed {
      logic              key_is_down;
      logic [DATA_W-1:0] press_ticks;
      logic              event_pending;
      logic [DATA_W-1:0] hold_countdown;
      logic              half_rate_toggle;
   } key_state_type;

endpackage

`default_nettype wire

[sv/kcd_if.sv]
`default_nettype none

interface kcd_req_if;
   logic valid;
   logic ready;
   logic kind;
   logic pin_released;

   modport source (output valid, output kind, output pin_released, input ready);
   modport sink (input valid, input kind, input pin_released, output ready);
endinterface

interface kcd_rsp_if;
   logic valid;
   logic ready;
   logic clicked;
   logic long_pressed;
   logic event_busy;

   modport source (output valid, output clicked, output long_pressed, output event_busy,
                   input ready);
   modport sink (input valid, input clicked, input long_pressed, input event_busy,
                 output ready);
endinterface

`default_nettype wire

[sv/key_click_long_press_detector.sv]
// Key click / long-press detector.
//
// req_ch carries one word per tick: kind selects a pin sample (tick) or a
// consume of the pending key event; pin_released is the active-low key pin.
// rsp_ch returns one word per request word: clicked, long_pressed and
// event_busy as they stand after that request.
// Latency: the response word is valid in the cycle after the request is
// accepted. Throughput: one request per cycle, set by the single output
// register; req_ch.ready is high while that register is empty or being taken.
// If the receiver stalls, the response is held and req_ch.ready drops until
// it is taken.
// The APB port (psel, penable, pwrite, paddr, pwdata, prdata, pready) holds
// click_min_time, click_max_time, long_press_time and click_hold_ticks at
// byte addresses 0, 4, 8 and 12; pready is always high.
// Synchronous reset empties the output register, clears the key state and
// loads the register defaults 8, 120, 254 and 255.
`default_nettype none

module key_click_long_press_detector (
   input  wire logic                         clock,
   input  wire logic                         reset,
   kcd_req_if.sink                           req_ch,
   kcd_rsp_if.source                         rsp_ch,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [kcd_pkg::PADDR_W-1:0]  paddr,
   input  wire logic [kcd_pkg::PDATA_W-1:0]  pwdata,
   output logic      [kcd_pkg::PDATA_W-1:0]  prdata,
   output logic                              pready
);

   kcd_pkg::cfg_type       cfg_ff, cfg_in;
   kcd_pkg::key_state_type st_ff, st_in, st_next;
   kcd_pkg::cfg_reg_type   reg_sel;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   clicked_ff, clicked_in;
   logic                   long_ff, long_in;
   logic                   busy_ff, busy_in;
   logic                   accept;
   logic                   in_window;
   logic [kcd_pkg::DATA_W-1:0] count_dec;
   logic [kcd_pkg::DATA_W-1:0] rd_val;

   assign pready = 1'b1;
   assign reg_sel = kcd_pkg::cfg_reg_type'(paddr[3:2]);

   always_comb begin
      cfg_in = cfg_ff;
      rd_val = '0;
      unique case (reg_sel)
         kcd_pkg::REG_CLICK_MIN: begin
            rd_val = cfg_ff.click_min_time;
            if (psel && penable && pwrite) cfg_in.click_min_time = pwdata[7:0];
         end
         kcd_pkg::REG_CLICK_MAX: begin
            rd_val = cfg_ff.click_max_time;
            if (psel && penable && pwrite) cfg_in.click_max_time = pwdata[7:0];
         end
         kcd_pkg::REG_LONG_PRESS: begin
            rd_val = cfg_ff.long_press_time;
            if (psel && penable && pwrite) cfg_in.long_press_time = pwdata[7:0];
         end
         kcd_pkg::REG_CLICK_HOLD: begin
            rd_val = cfg_ff.click_hold_ticks;
            if (psel && penable && pwrite) cfg_in.click_hold_ticks = pwdata[7:0];
         end
         default: rd_val = '0;
      endcase
   end

   assign prdata = {{(kcd_pkg::PDATA_W - kcd_pkg::DATA_W){1'b0}}, rd_val};

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept = req_ch.valid && req_ch.ready;

   assign in_window = (st_ff.press_ticks > cfg_ff.click_min_time) &&
                      (st_ff.press_ticks < cfg_ff.click_max_time);
   assign count_dec = (st_ff.hold_countdown != '0) ?
                      st_ff.hold_countdown - 8'd1 : st_ff.hold_countdown;

   always_comb begin
      st_next = st_ff;
      if (req_ch.kind == kcd_pkg::KIND_CONSUME) begin
         st_next.event_pending = 1'b0;
      end else if (req_ch.pin_released) begin
         if (st_ff.key_is_down) begin
            st_next.key_is_down = 1'b0;
            if (st_ff.press_ticks > cfg_ff.long_press_time) begin
               st_next.event_pending = 1'b0;
               st_next.press_ticks = '0;
            end else if (in_window) begin
               st_next.hold_countdown = cfg_ff.click_hold_ticks;
            end
         end else if (st_ff.event_pending) begin
            st_next.hold_countdown = count_dec;
            if (count_dec == '0) begin
               st_next.event_pending = 1'b0;
               st_next.press_ticks = '0;
            end
         end
      end else if (!st_ff.key_is_down) begin
         st_next.key_is_down = 1'b1;
         st_next.press_ticks = '0;
         st_next.event_pending = 1'b1;
         st_next.hold_countdown = '0;
      end else begin
         st_next.half_rate_toggle = !st_ff.half_rate_toggle;
         if (st_ff.half_rate_toggle && (st_ff.press_ticks != kcd_pkg::PRESS_SATURATE)) begin
            st_next.press_ticks = st_ff.press_ticks + 8'd1;
         end
      end
   end

   always_comb begin
      st_in = st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      clicked_in = clicked_ff;
      long_in = long_ff;
      busy_in = busy_ff;
      if (accept) begin
         st_in = st_next;
         rsp_valid_in = 1'b1;
         clicked_in = st_next.event_pending && !st_next.key_is_down &&
                      (st_next.press_ticks > cfg_ff.click_min_time) &&
                      (st_next.press_ticks < cfg_ff.click_max_time);
         long_in = st_next.event_pending &&
                   (st_next.press_ticks > cfg_ff.long_press_time);
         busy_in = st_next.event_pending;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.click_min_time <= kcd_pkg::CLICK_MIN_RESET;
         cfg_ff.click_max_time <= kcd_pkg::CLICK_MAX_RESET;
         cfg_ff.long_press_time <= kcd_pkg::LONG_PRESS_RESET;
         cfg_ff.click_hold_ticks <= kcd_pkg::CLICK_HOLD_RESET;
         st_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         st_ff <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      clicked_ff <= clicked_in;
      long_ff <= long_in;
      busy_ff <= busy_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.clicked = clicked_ff;
   assign rsp_ch.long_pressed = long_ff;
   assign rsp_ch.event_busy = busy_ff;

endmodule

`default_nettype wire

[sv/kcd_checker.sv]
`default_nettype none

module kcd_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic req_kind,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_clicked,
   input wire logic rsp_long_pressed,
   input wire logic rsp_event_busy
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

   a_flags_need_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((!rsp_clicked && !rsp_long_pressed) || rsp_event_busy))
      else $error("click or long press reported without a pending event");

   a_consume_clears: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == kcd_pkg::KIND_CONSUME)
      |=> rsp_valid && !rsp_event_busy)
      else $error("consume did not clear the pending event");

endmodule

bind key_click_long_press_detector kcd_checker u_kcd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .req_kind         (req_ch.kind),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_clicked      (rsp_ch.clicked),
   .rsp_long_pressed (rsp_ch.long_pressed),
   .rsp_event_busy   (rsp_ch.event_busy)
);

`default_nettype wire

[tb/key_click_long_press_detector_tb.sv]
`timescale 1ns / 1ps

module key_click_long_press_detector_tb;

   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned PHASES = 8;

   typedef struct packed {
      kcd_pkg::kind_type kind;
      logic              pin_released;
   } key_word_type;

   typedef struct packed {
      logic clicked;
      logic long_pressed;
      logic event_busy;
   } key_flags_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                         psel = 1'b0;
   logic                         penable = 1'b0;
   logic                         pwrite = 1'b0;
   logic [kcd_pkg::PADDR_W-1:0]  paddr = '0;
   logic [kcd_pkg::PDATA_W-1:0]  pwdata = '0;
   logic [kcd_pkg::PDATA_W-1:0]  prdata;
   logic                         pready;

   kcd_req_if req_if ();
   kcd_rsp_if rsp_if ();

   key_click_long_press_detector u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_if),
      .rsp_ch  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   kcd_pkg::cfg_type       knobs = '{kcd_pkg::CLICK_MIN_RESET, kcd_pkg::CLICK_MAX_RESET,
                                     kcd_pkg::LONG_PRESS_RESET, kcd_pkg::CLICK_HOLD_RESET};
   kcd_pkg::key_state_type key_st = '0;

   key_word_type  key_words[$];
   key_flags_type flags_due[$];

   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles = 0;
   int unsigned queued_words = 0;
   logic        req_fire = 1'b0;
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   logic [11:0] stall_pat = '1;
   int unsigned stall_pos = 0;

   function automatic logic in_click_window();
      return key_st.press_ticks > knobs.click_min_time &&
             key_st.press_ticks < knobs.click_max_time;
   endfunction

   function automatic key_flags_type advance_key(kcd_pkg::kind_type kind, logic released);
      key_flags_type f;
      if (kind == kcd_pkg::KIND_CONSUME) begin
         key_st.event_pending = 1'b0;
      end else if (released) begin
         if (key_st.key_is_down) begin
            key_st.key_is_down = 1'b0;
            if (key_st.press_ticks > knobs.long_press_time) begin
               key_st.event_pending = 1'b0;
               key_st.press_ticks = '0;
            end else if (in_click_window()) begin
               key_st.hold_countdown = knobs.click_hold_ticks;
            end
         end else if (key_st.event_pending) begin
            if (key_st.hold_countdown != 0)
               key_st.hold_countdown = key_st.hold_countdown - 1'b1;
            if (key_st.hold_countdown == 0) begin
               key_st.event_pending = 1'b0;
               key_st.press_ticks = '0;
            end
         end
      end else if (!key_st.key_is_down) begin
         key_st.key_is_down = 1'b1;
         key_st.press_ticks = '0;
         key_st.event_pending = 1'b1;
         key_st.hold_countdown = '0;
      end else begin
         key_st.half_rate_toggle = !key_st.half_rate_toggle;
         if (!key_st.half_rate_toggle && key_st.press_ticks != kcd_pkg::PRESS_SATURATE)
            key_st.press_ticks = key_st.press_ticks + 1'b1;
      end
      f.clicked = key_st.event_pending && !key_st.key_is_down && in_click_window();
      f.long_pressed = key_st.event_pending && key_st.press_ticks > knobs.long_press_time;
      f.event_busy = key_st.event_pending;
      return f;
   endfunction

   task automatic push_word(kcd_pkg::kind_type kind, logic released);
      key_word_type w;
      w.kind = kind;
      w.pin_released = released;
      key_words.push_back(w);
      queued_words++;
   endtask

   task automatic push_ticks(logic released, int unsigned count);
      repeat (count) push_word(kcd_pkg::KIND_TICK, released);
   endtask

   task automatic csr_write(kcd_pkg::cfg_reg_type idx, logic [kcd_pkg::DATA_W-1:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= kcd_pkg::PDATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         kcd_pkg::REG_CLICK_MIN:  knobs.click_min_time = value;
         kcd_pkg::REG_CLICK_MAX:  knobs.click_max_time = value;
         kcd_pkg::REG_LONG_PRESS: knobs.long_press_time = value;
         kcd_pkg::REG_CLICK_HOLD: knobs.click_hold_ticks = value;
         default: ;
      endcase
      @(negedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== kcd_pkg::PDATA_W'(value)) begin
         mismatch_count++;
         $display("%0t: register %s readback: expected %0h, got %0h",
                  $time, idx.name(), value, prdata);
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_knobs(kcd_pkg::cfg_type c);
      csr_write(kcd_pkg::REG_CLICK_MIN, c.click_min_time);
      csr_write(kcd_pkg::REG_CLICK_MAX, c.click_max_time);
      csr_write(kcd_pkg::REG_LONG_PRESS, c.long_press_time);
      csr_write(kcd_pkg::REG_CLICK_HOLD, c.click_hold_ticks);
   endtask

   task automatic wait_drained();
      while (key_words.size() != 0 || flags_due.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic push_press();
      int t;
      int p;
      int unsigned held;
      int unsigned rest;
      int unsigned cut;
      case ($urandom_range(0, 3))
         0: t = knobs.click_min_time;
         1: t = knobs.click_max_time;
         2: t = knobs.long_press_time;
         default: t = $urandom_range(0, 12);
      endcase
      p = t + $urandom_range(0, 2) - 1;
      if (p < 0) p = 0;
      if (p > 255) p = 255;
      held = 1 + 2 * p + $urandom_range(0, 1);
      if (p >= 254) held += $urandom_range(0, 6);
      if ($urandom_range(0, 5) == 0) begin
         cut = $urandom_range(1, held);
         push_ticks(1'b0, cut);
         push_word(kcd_pkg::KIND_CONSUME, 1'($urandom_range(0, 1)));
         push_ticks(1'b0, held - cut);
      end else begin
         push_ticks(1'b0, held);
      end
      if ($urandom_range(0, 1) == 0)
         rest = 1 + $urandom_range(0, 3);
      else
         rest = knobs.click_hold_ticks + $urandom_range(0, 2);
      push_ticks(1'b1, rest);
      if ($urandom_range(0, 2) == 0)
         push_word(kcd_pkg::KIND_CONSUME, 1'($urandom_range(0, 1)));
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_fire) begin
            void'(key_words.pop_front());
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            end
         end
         if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (key_words.size() != 0) begin
            req_if.valid <= 1'b1;
            req_if.kind <= key_words[0].kind;
            req_if.pin_released <= key_words[0].pin_released;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= stall_pat[stall_pos];
         stall_pos = (stall_pos + 1) % 12;
         if (stall_pos == 0 && $urandom_range(0, 3) == 0)
            stall_pat = ($urandom_range(0, 2) == 0) ? '1 : 12'($urandom);
      end
   end

   always @(posedge clock) begin
      key_flags_type got;
      key_flags_type want;
      if (reset) begin
         req_fire = 1'b0;
         quiet_cycles = 0;
      end else begin
         req_fire = req_if.valid && req_if.ready;
         if (rsp_if.valid && rsp_if.ready) begin
            got = {rsp_if.clicked, rsp_if.long_pressed, rsp_if.event_busy};
            if (flags_due.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected word: clicked=%b long_pressed=%b event_busy=%b",
                        $time, got.clicked, got.long_pressed, got.event_busy);
            end else begin
               want = flags_due.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  $display({"%0t: expected clicked=%b long_pressed=%b event_busy=%b,",
                            " got clicked=%b long_pressed=%b event_busy=%b"}, $time,
                           want.clicked, want.long_pressed, want.event_busy,
                           got.clicked, got.long_pressed, got.event_busy);
               end
            end
         end
         if (req_fire)
            flags_due.push_back(advance_key(kcd_pkg::kind_type'(req_if.kind),
                                            req_if.pin_released));
         if (req_fire || (rsp_if.valid && rsp_if.ready) || (psel && penable && pready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("key_click_long_press_detector_tb: errors");
            $finish;
         end
      end
   end

   initial begin
      kcd_pkg::cfg_type next_knobs;
      int unsigned      budget;
      req_if.valid = 1'b0;
      req_if.kind = kcd_pkg::KIND_TICK;
      req_if.pin_released = 1'b1;
      rsp_if.ready = 1'b0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      // tight thresholds so short presses reach every outcome
      set_knobs('{8'd0, 8'd3, 8'd4, 8'd2});
      push_word(kcd_pkg::KIND_TICK, 1'b1);
      push_word(kcd_pkg::KIND_CONSUME, 1'b1);
      push_ticks(1'b0, 3);
      push_ticks(1'b1, 2);
      push_word(kcd_pkg::KIND_CONSUME, 1'b0);
      push_word(kcd_pkg::KIND_TICK, 1'b1);
      push_ticks(1'b0, 11);
      push_word(kcd_pkg::KIND_TICK, 1'b1);
      push_word(kcd_pkg::KIND_TICK, 1'b0);
      push_ticks(1'b1, 2);
      wait_drained();

      for (int unsigned ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: next_knobs = '{kcd_pkg::CLICK_MIN_RESET, kcd_pkg::CLICK_MAX_RESET,
                              kcd_pkg::LONG_PRESS_RESET, kcd_pkg::CLICK_HOLD_RESET};
            1: next_knobs = '{8'd0, 8'd0, 8'd0, 8'd0};
            2: next_knobs = '{8'hff, 8'hff, 8'hff, 8'hff};
            3: next_knobs = '{8'd0, 8'hff, 8'hff, 8'd0};
            default: next_knobs = '{8'($urandom_range(0, 10)), 8'($urandom_range(0, 20)),
                                    8'($urandom_range(0, 24)), 8'($urandom_range(0, 6))};
         endcase
         set_knobs(next_knobs);
         budget = (ph == 0) ? 300 : 180;
         queued_words = 0;
         while (queued_words < budget) begin
            if ($urandom_range(0, 7) == 0) begin
               repeat ($urandom_range(1, 6))
                  push_word(kcd_pkg::kind_type'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
            end else begin
               push_press();
            end
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (flags_due.size() != 0) begin
         mismatch_count++;
         $display("%0t: %0d expected words never arrived", $time, flags_due.size());
      end
      if (mismatch_count == 0)
         $display("key_click_long_press_detector_tb: clean");
      else
         $display("key_click_long_press_detector_tb: errors");
      $finish;
   end

endmodule
